// ===== rtl/mttg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the sine table generator for the tone generator.
package mttg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int PHASE_W    = 32;
	localparam int LEN_W      = 24;
	localparam int SQP_W      = 16;
	localparam int PLK_W      = 11;
	localparam int TIMBRE_W   = 3;
	localparam int FADE_W     = 16;
	localparam int SEED_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int SINE_BITS  = 10;
	localparam int TBL_N      = 1 << SINE_BITS;
	localparam int TI_W       = SINE_BITS + 1;
	localparam int FB         = 16;
	localparam int PR_W       = SINE_BITS + FB;
	localparam int Q30_W      = 31;
	localparam int SCALE_SH   = 31 - SAMPLE_W;

	localparam int DW         = 48;
	localparam int DIV_STEPS  = DW - 1;
	localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_TIMBRE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DETUNE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd3;

	localparam logic [TIMBRE_W-1:0] TIMBRE_SINE = 3'd0;
	localparam logic [TIMBRE_W-1:0] TIMBRE_MIX  = 3'd1;
	localparam logic [TIMBRE_W-1:0] TIMBRE_TRI  = 3'd2;
	localparam logic [TIMBRE_W-1:0] TIMBRE_SAW  = 3'd3;
	localparam logic [TIMBRE_W-1:0] TIMBRE_SQR  = 3'd4;

	localparam logic [TIMBRE_W-1:0]   TIMBRE_RST = 3'd0;
	localparam logic [FADE_W-1:0]     FADE_RST   = 16'd882;
	localparam logic [PHASE_W-1:0]    DETUNE_RST = 32'd486958;
	localparam logic [SEED_W-1:0]     SEED_RST   = 16'd44257;
	localparam logic [SEED_W-1:0]     LFSR_TAPS  = 16'hB400;
	// Rounded-up 2^36/5 and the bias 5*2^30 for the floor division by five.
	localparam logic [33:0]           MIX_RECIP  = 34'h3_3333_3334;
	localparam logic [33:0]           MIX_BIAS   = 34'h1_4000_0000;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_RDB, ST_PLUCK, ST_SIN_SET, ST_SIN_RD0, ST_SIN_RD1,
		ST_SIN_DIFF, ST_SIN_MUL, ST_SIN_SUM, ST_WAVE, ST_DIV_MIX, ST_WAIT_MIX,
		ST_DIV_FADE, ST_WAIT_FADE, ST_EMIT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_TAKE, OP_ZERO, OP_RDA, OP_RDB, OP_PLUCK, OP_SIN_SET, OP_SIN_RD0,
		OP_SIN_RD1, OP_SIN_DIFF, OP_SIN_MUL, OP_SIN_SUM, OP_WAVE, OP_DIV_MIX,
		OP_MIX_Q, OP_DIV_FADE, OP_FINISH, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sel;
	} cmd_t;

	typedef struct packed {
		logic run;
		logic mix;
		logic div_busy;
		logic out_full;
	} stat_t;

	// Quarter-wave sine entry k in Q30 from a truncated Taylor series.
	function automatic logic [Q30_W-1:0] sine_entry(input int unsigned k);
		longint unsigned x;
		longint unsigned t;
		longint s;
		x = (64'd1686629713 * 64'(k)) >> SINE_BITS;
		t = x;
		s = longint'(x);
		t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd6;   s = s - longint'(t);
		t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd20;  s = s + longint'(t);
		t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd42;  s = s - longint'(t);
		t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd72;  s = s + longint'(t);
		t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd110; s = s - longint'(t);
		t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd156; s = s + longint'(t);
		t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd210; s = s - longint'(t);
		t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd272; s = s + longint'(t);
		if (s < 0) s = 0;
		if (s > 64'sd1073741824) s = 64'sd1073741824;
		return Q30_W'(s);
	endfunction

endpackage

// ===== rtl/mttg_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tone commands and output samples.
interface mttg_in_if;
	import mttg_pkg::*;
	logic               valid;
	logic               ready;
	logic               action;
	logic [PHASE_W-1:0] phase_step;
	logic [LEN_W-1:0]   tone_length;
	logic [SQP_W-1:0]   square_period;
	logic [PLK_W-1:0]   pluck_period;
	modport source (output valid, action, phase_step, tone_length, square_period,
		pluck_period, input ready);
	modport sink (input valid, action, phase_step, tone_length, square_period,
		pluck_period, output ready);
endinterface

interface mttg_out_if;
	import mttg_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;
	logic                       active;
	modport source (output valid, sample, last_sample, active, input ready);
	modport sink (input valid, sample, last_sample, active, output ready);
endinterface

// ===== rtl/mttg_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mttg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/mttg_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine for one sample: pluck, sine lookups, waveform, mix divide, fade.
module mttg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mttg_pkg::stat_t stat,
	output mttg_pkg::cmd_t  cmd
);
	import mttg_pkg::*;

	state_t state_q, state_d;
	logic   sel_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_CHECK;
			ST_CHECK:     state_d = stat.run ? ST_RDB : ST_EMIT;
			ST_RDB:       state_d = ST_PLUCK;
			ST_PLUCK:     state_d = ST_SIN_SET;
			ST_SIN_SET:   state_d = ST_SIN_RD0;
			ST_SIN_RD0:   state_d = ST_SIN_RD1;
			ST_SIN_RD1:   state_d = ST_SIN_DIFF;
			ST_SIN_DIFF:  state_d = ST_SIN_MUL;
			ST_SIN_MUL:   state_d = ST_SIN_SUM;
			ST_SIN_SUM:   state_d = (stat.mix && !sel_q) ? ST_SIN_SET : ST_WAVE;
			ST_WAVE:      state_d = stat.mix ? ST_DIV_MIX : ST_DIV_FADE;
			ST_DIV_MIX:   state_d = ST_WAIT_MIX;
			ST_WAIT_MIX:  if (!stat.div_busy) state_d = ST_DIV_FADE;
			ST_DIV_FADE:  state_d = ST_WAIT_FADE;
			ST_WAIT_FADE: if (!stat.div_busy) state_d = ST_EMIT;
			ST_EMIT:      if (!stat.out_full) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.sel  = sel_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_TAKE;
			end
			ST_CHECK:     cmd.op = stat.run ? OP_RDA : OP_ZERO;
			ST_RDB:       cmd.op = OP_RDB;
			ST_PLUCK:     cmd.op = OP_PLUCK;
			ST_SIN_SET:   cmd.op = OP_SIN_SET;
			ST_SIN_RD0:   cmd.op = OP_SIN_RD0;
			ST_SIN_RD1:   cmd.op = OP_SIN_RD1;
			ST_SIN_DIFF:  cmd.op = OP_SIN_DIFF;
			ST_SIN_MUL:   cmd.op = OP_SIN_MUL;
			ST_SIN_SUM:   cmd.op = OP_SIN_SUM;
			ST_WAVE:      cmd.op = OP_WAVE;
			ST_DIV_MIX:   cmd.op = OP_DIV_MIX;
			ST_WAIT_MIX:  cmd.op = stat.div_busy ? OP_NONE : OP_MIX_Q;
			ST_DIV_FADE:  cmd.op = OP_DIV_FADE;
			ST_WAIT_FADE: cmd.op = stat.div_busy ? OP_NONE : OP_FINISH;
			ST_EMIT:      cmd.op = stat.out_full ? OP_NONE : OP_EMIT;
			default:      cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				sel_q <= 1'b0;
			end else if (state_q == ST_SIN_SUM && stat.mix && !sel_q) begin
				sel_q <= 1'b1;
			end
		end
	end
endmodule

// ===== rtl/mttg_dp.sv =====
`timescale 1ns / 1ps
// Datapath: tone state, string delay line, sine ROM, waveform, mix divide, fade divider.
module mttg_dp #(
	parameter int DELAY_DEPTH = 2048
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mttg_pkg::cmd_t                       cmd,
	output mttg_pkg::stat_t                      stat,
	input  logic                                 cfg_we,
	input  logic [mttg_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [mttg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 action,
	input  logic [mttg_pkg::PHASE_W-1:0]         phase_step,
	input  logic [mttg_pkg::LEN_W-1:0]           tone_length,
	input  logic [mttg_pkg::SQP_W-1:0]           square_period,
	input  logic [mttg_pkg::PLK_W-1:0]           pluck_period,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic signed [mttg_pkg::SAMPLE_W-1:0] sample,
	output logic                                 last_sample,
	output logic                                 active
);
	import mttg_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);

	// Configuration registers.
	logic [TIMBRE_W-1:0] timbre_q;
	logic [FADE_W-1:0]   fade_q;
	logic [PHASE_W-1:0]  detune_q;
	logic [SEED_W-1:0]   seed_q;

	// Tone state.
	logic [PHASE_W-1:0]  step_q, main_ph_q, det_ph_q;
	logic [LEN_W-1:0]    len_q, idx_q;
	logic [SQP_W-1:0]    sqp_q, sqcnt_q;
	logic [PLK_W-1:0]    plk_q;
	logic [SEED_W-1:0]   lfsr_q;
	logic                run_q;
	logic [AW-1:0]       wp_q;

	// Work registers.
	logic signed [SAMPLE_W-1:0] a_q, e_q;
	logic [1:0]                 sn_quad_q;
	logic [TI_W-1:0]            sn_idx_q;
	logic [FB-1:0]              sn_frac_q;
	logic [Q30_W-1:0]           rom_q, v0_q;
	logic signed [31:0]         d_q, sm_q, sd_q, x_q;
	logic signed [DW-1:0]       ip_q;
	logic [16:0]                mix_hi_q;
	logic [50:0]                mix_lo_q;
	logic [DW-2:0]              div_n_q;
	logic [FADE_W-1:0]          div_r_q, div_d_q;
	logic                       div_neg_q;
	logic [DCNT_W-1:0]          div_cnt_q;
	logic signed [SAMPLE_W-1:0] res_sample_q;
	logic                       res_last_q, res_active_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_last_q, out_active_q;

	// Delay line access.
	logic                       ge;
	logic [AW-1:0]              p_aw, a_addr, b_addr, raddr;
	logic [AW:0]                pdiff;
	logic [SAMPLE_W-1:0]        rd_data;
	logic signed [SAMPLE_W-1:0] b_val, e_w;
	logic signed [SAMPLE_W:0]   avg_sum;
	logic [SEED_W-1:0]          lfsr_nx;

	assign ge     = idx_q >= LEN_W'(plk_q);
	assign p_aw   = AW'(plk_q);
	assign pdiff  = {1'b0, wp_q} - {1'b0, p_aw};
	assign a_addr = pdiff[AW] ? AW'(pdiff + (AW + 1)'(DELAY_DEPTH)) : pdiff[AW-1:0];
	assign b_addr = (a_addr == AW'(DELAY_DEPTH - 1)) ? '0 : a_addr + 1'b1;
	assign raddr  = (cmd.op == OP_RDB) ? b_addr : a_addr;
	// With a period of one the second tap would be the sample being made.
	assign b_val   = (plk_q == PLK_W'(1)) ? '0 : $signed(rd_data);
	assign avg_sum = (SAMPLE_W + 1)'(a_q) + (SAMPLE_W + 1)'(b_val);
	assign e_w     = ge ? SAMPLE_W'(avg_sum >>> 1) : $signed(lfsr_q ^ 16'h8000);
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	mttg_ram #(.WIDTH(SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_delay (
		.clk   (clk),
		.we    (cmd.op == OP_PLUCK),
		.waddr (wp_q),
		.wdata (e_w),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Sine quarter-wave ROM, read one entry per cycle.
	logic [Q30_W-1:0]     sine_rom [0:TBL_N];
	logic [PHASE_W-1:0]   ph;
	logic [PR_W-1:0]      pr;
	logic [PR_W:0]        pf;
	logic [TI_W-1:0]      idx1, rom_addr;
	logic signed [32:0]   vsum;
	logic signed [31:0]   vsel, sv;

	for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
		assign sine_rom[k] = sine_entry(k);
	end

	assign ph       = cmd.sel ? det_ph_q : main_ph_q;
	assign pr       = ph[PHASE_W-3 -: PR_W];
	assign pf       = ph[PHASE_W-2] ? ((PR_W + 1)'(1) << PR_W) - {1'b0, pr} : {1'b0, pr};
	assign idx1     = (sn_idx_q == TI_W'(TBL_N)) ? sn_idx_q : sn_idx_q + 1'b1;
	assign rom_addr = (cmd.op == OP_SIN_RD1) ? idx1 : sn_idx_q;
	assign vsum     = 33'($signed({1'b0, v0_q})) + 33'(32'(ip_q >>> FB));
	assign vsel     = (sn_idx_q == TI_W'(TBL_N)) ? $signed({1'b0, v0_q}) : 32'(vsum);
	assign sv       = sn_quad_q[1] ? -vsel : vsel;

	// Waveform value in Q30.
	logic [29:0]          fq;
	logic signed [33:0]   tri_t, tri_a;
	logic signed [31:0]   x_w;

	assign fq    = main_ph_q[PHASE_W-1 -: 30];
	assign tri_t = $signed({2'b00, fq, 2'b00}) - 34'sh0_8000_0000;
	assign tri_a = tri_t[33] ? -tri_t : tri_t;

	always_comb begin
		if (step_q == '0) begin
			x_w = '0;
		end else begin
			case (timbre_q)
				TIMBRE_SINE, TIMBRE_MIX: x_w = sm_q;
				TIMBRE_TRI: x_w = 32'(tri_a - 34'sh0_4000_0000);
				TIMBRE_SAW: x_w = $signed({1'b0, fq, 1'b0}) - 32'sh4000_0000;
				TIMBRE_SQR: x_w = ({1'b0, sqcnt_q} < ({1'b0, sqp_q} >> 1)) ?
					-32'sh4000_0000 : 32'sh4000_0000;
				default:    x_w = 32'(e_q) <<< 15;
			endcase
		end
	end

	// Fade multiplier and divider operands.
	logic [FADE_W-1:0]    fl, m_w;
	logic [LEN_W-1:0]     rem_len, mi;
	logic signed [DW-1:0] fprod, dm, qpos, qfin, y_w;
	logic [DW-1:0]        div_mag;
	logic [FADE_W:0]      div_r2;
	logic                 div_bit;

	// The mix is biased to be non-negative and divided by five through the
	// rounded-up reciprocal; the product is exact for values below 2^34.
	logic [33:0]          mix_n;
	logic [50:0]          mix_hp;
	logic [67:0]          mix_acc;
	logic signed [31:0]   mix_x;

	assign fl      = (fade_q == '0) ? FADE_W'(1) : fade_q;
	assign rem_len = len_q - idx_q;
	assign mi      = (rem_len < idx_q) ? rem_len : idx_q;
	assign m_w     = (mi > LEN_W'(fl)) ? fl : FADE_W'(mi);
	assign fprod   = x_q * $signed({1'b0, m_w});
	assign dm      = (DW'(sm_q) <<< 1) + DW'(sm_q) - (DW'(sd_q) <<< 1);
	assign mix_n   = 34'(dm + DW'(MIX_BIAS));
	assign mix_hp  = 51'(mix_hi_q) * 51'(MIX_RECIP);
	assign mix_acc = {mix_hp, 17'b0} + 68'(mix_lo_q);
	assign mix_x   = $signed(mix_acc[67:36] - 32'h4000_0000);
	assign div_mag = fprod[DW-1] ? DW'(-fprod) : DW'(fprod);
	assign div_r2  = {div_r_q, div_n_q[DW-2]};
	assign div_bit = div_r2 >= {1'b0, div_d_q};
	assign qpos    = $signed({1'b0, div_n_q});
	assign qfin    = div_neg_q ? (-qpos - DW'(div_r_q != '0)) : qpos;
	assign y_w     = qfin >>> SCALE_SH;

	logic signed [SAMPLE_W-1:0] y_sat;
	logic                       last_w;

	assign y_sat  = (y_w > DW'(32767)) ? 16'sh7FFF :
		(y_w < -DW'(32768)) ? -16'sh8000 : SAMPLE_W'(y_w);
	assign last_w = (idx_q + 1'b1) == len_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timbre_q <= TIMBRE_RST;
			fade_q   <= FADE_RST;
			detune_q <= DETUNE_RST;
			seed_q   <= SEED_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TIMBRE: timbre_q <= cfg_wdata[TIMBRE_W-1:0];
				REG_FADE:   fade_q   <= cfg_wdata[FADE_W-1:0];
				REG_DETUNE: detune_q <= cfg_wdata[PHASE_W-1:0];
				REG_SEED:   seed_q   <= cfg_wdata[SEED_W-1:0];
				default:    ;
			endcase
		end
	end

	// Tone state and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			len_q       <= '0;
			sqp_q       <= SQP_W'(1);
			plk_q       <= PLK_W'(1);
			main_ph_q   <= '0;
			det_ph_q    <= '0;
			idx_q       <= '0;
			sqcnt_q     <= '0;
			lfsr_q      <= SEED_RST;
			run_q       <= 1'b0;
			wp_q        <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_TAKE: begin
					if (action) begin
						step_q    <= phase_step;
						len_q     <= tone_length;
						sqp_q     <= (square_period == '0) ? SQP_W'(1) : square_period;
						if (pluck_period == '0) begin
							plk_q <= PLK_W'(1);
						end else if (32'(pluck_period) > 32'(DELAY_DEPTH - 1)) begin
							plk_q <= PLK_W'(DELAY_DEPTH - 1);
						end else begin
							plk_q <= pluck_period;
						end
						main_ph_q <= '0;
						det_ph_q  <= '0;
						idx_q     <= '0;
						sqcnt_q   <= '0;
						wp_q      <= '0;
						lfsr_q    <= (seed_q == '0) ? SEED_W'(1) : seed_q;
						run_q     <= tone_length != '0;
					end
				end
				OP_PLUCK: begin
					if (!ge) lfsr_q <= lfsr_nx;
				end
				OP_DIV_FADE: begin
					div_cnt_q <= DCNT_W'(DIV_STEPS);
				end
				OP_FINISH: begin
					main_ph_q <= main_ph_q + step_q;
					det_ph_q  <= det_ph_q + step_q + detune_q;
					sqcnt_q   <= (({1'b0, sqcnt_q} + 1'b1) >= {1'b0, sqp_q}) ?
						'0 : sqcnt_q + 1'b1;
					idx_q     <= idx_q + 1'b1;
					wp_q      <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
					if (last_w) run_q <= 1'b0;
				end
				OP_EMIT: begin
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rom_q <= sine_rom[rom_addr];
		if (div_cnt_q != '0) begin
			div_n_q <= {div_n_q[DW-3:0], div_bit};
			div_r_q <= div_bit ? FADE_W'(div_r2 - {1'b0, div_d_q}) : FADE_W'(div_r2);
		end
		case (cmd.op)
			OP_ZERO: begin
				res_sample_q <= '0;
				res_last_q   <= 1'b0;
				res_active_q <= 1'b0;
			end
			OP_RDB:      a_q <= $signed(rd_data);
			OP_PLUCK:    e_q <= e_w;
			OP_SIN_SET: begin
				sn_quad_q <= ph[PHASE_W-1 -: 2];
				sn_idx_q  <= pf[PR_W -: TI_W];
				sn_frac_q <= pf[FB-1:0];
			end
			OP_SIN_RD1:  v0_q <= rom_q;
			OP_SIN_DIFF: d_q  <= $signed({1'b0, rom_q}) - $signed({1'b0, v0_q});
			OP_SIN_MUL:  ip_q <= d_q * $signed({1'b0, sn_frac_q});
			OP_SIN_SUM: begin
				if (cmd.sel) sd_q <= sv;
				else         sm_q <= sv;
			end
			OP_WAVE:     x_q <= x_w;
			OP_DIV_MIX: begin
				mix_hi_q <= mix_n[33:17];
				mix_lo_q <= 51'(mix_n[16:0]) * 51'(MIX_RECIP);
			end
			OP_DIV_FADE: begin
				div_n_q   <= div_mag[DW-2:0];
				div_r_q   <= '0;
				div_d_q   <= fl;
				div_neg_q <= fprod[DW-1];
			end
			OP_MIX_Q:    x_q <= mix_x;
			OP_FINISH: begin
				res_sample_q <= y_sat;
				res_last_q   <= last_w;
				res_active_q <= 1'b1;
			end
			OP_EMIT: begin
				out_sample_q <= res_sample_q;
				out_last_q   <= res_last_q;
				out_active_q <= res_active_q;
			end
			default: ;
		endcase
	end

	assign stat.run      = run_q;
	assign stat.mix      = (timbre_q == TIMBRE_MIX) && (step_q != '0);
	assign stat.div_busy = div_cnt_q != '0;
	assign stat.out_full = out_valid_q;

	assign out_valid   = out_valid_q;
	assign sample      = out_sample_q;
	assign last_sample = out_last_q;
	assign active      = out_active_q;

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINISH && last_w) |=> !run_q)
		else $error("tone still running after its last sample");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(div_cnt_q != '0) |=> (div_cnt_q == $past(div_cnt_q) - 1'b1))
		else $error("divider step count did not advance");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (idx_q < len_q))
		else $error("sample index past tone length while running");
	a_emit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> !out_valid_q)
		else $error("result loaded over an untaken output beat");
endmodule

// ===== rtl/multi_timbre_tone_generator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the multi-timbre tone generator.
// Input channel in_ch carries one command beat per sample: action 1 latches a new
// tone (phase step, length, square and pluck periods) and yields its first sample,
// action 0 yields the next sample. Every input beat produces exactly one output
// beat on out_ch with the signed sample, a last-sample flag and an active flag.
// Configuration (timbre, fade length, detune step, noise seed) is written through
// cfg_we / cfg_idx / cfg_wdata; the user must write it only while no sample is in
// flight; the block itself does not enforce this. An accepted beat goes through
// delay line and sine ROM access, the waveform step and a bit-serial divide for
// the fade. The mixed sine timbre adds a second sine lookup and a multiply by the
// reciprocal of five in ST_DIV_MIX and ST_WAIT_MIX. A new beat can be taken in
// the cycle after the previous result is loaded into the output register.
// Reset returns the control, configuration and tone state registers to their
// defaults and leaves no tone running; the delay line needs no clearing since a
// tone only reads what it wrote itself.
// When the receiver stalls, the finished sample waits in the output register and
// the next beat is computed behind it, then held until that slot frees.
module multi_timbre_tone_generator_unit #(
	parameter int DELAY_DEPTH = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mttg_in_if.sink                             in_ch,
	mttg_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [mttg_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mttg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import mttg_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mttg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mttg_dp #(.DELAY_DEPTH(DELAY_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.action        (in_ch.action),
		.phase_step    (in_ch.phase_step),
		.tone_length   (in_ch.tone_length),
		.square_period (in_ch.square_period),
		.pluck_period  (in_ch.pluck_period),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.sample        (out_ch.sample),
		.last_sample   (out_ch.last_sample),
		.active        (out_ch.active)
	);
endmodule
